@@ hw/rtl/hrss_pkg.sv @@
// ----------------------------------------------------------------------------
// hrss_pkg: shared types and constants
// Widths, status codes, register indexes and the bit-length helper used by
// the halving ring step schedule block.
// ----------------------------------------------------------------------------
package hrss_pkg;

  localparam int RANK_W        = 7;
  localparam int SLICE_W       = 6;
  localparam int STEP_W        = 4;
  localparam int SHIFT_W       = 3;
  localparam int UNIT_W        = 8;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 7;
  localparam int CNT_CAP       = 32;
  localparam int MAX_RANKS_DEF = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_RANK_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MY_RANK    = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FEW      = 2'd1,
    STAT_BAD_RANK = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_LO    = 7'b0001000,
    S_HI    = 7'b0010000,
    S_DSL   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  function automatic logic [SHIFT_W-1:0] bit_len(input logic [RANK_W-1:0] v);
    logic [SHIFT_W-1:0] n;
    n = '0;
    for (int i = 0; i < RANK_W; i++) begin
      if (v[i]) begin
        n = SHIFT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/halving_ring_step_schedule.sv @@
// ----------------------------------------------------------------------------
// halving_ring_step_schedule: all-reduce step schedule generator
// Takes one step number and emits one beat per slice exchanged in that step:
// peers, slice count, transmit/receive slice and a last flag.
//
//   channel   signals                          direction
//   in        in_valid/in_ready, step_index     input beat, one per step
//   out       out_valid/out_ready, result       one beat per slice
//   cfg       cfg_we, cfg_addr, cfg_data        register write, no wait
//
// A step first runs its setup through one shared wrapping subtractor
// (step modulo the phase length, peer and stride arithmetic), then emits one
// slice beat per cycle while the output is not stalled, and returns to idle.
// Error steps go from the check state straight to emit and give a single beat.
// in_ready is high only while idle; a stalled output beat holds the sequencer.
// Reset: rank_count 2, my_rank 0, no beat pending.
// ----------------------------------------------------------------------------
module halving_ring_step_schedule #(
  parameter int MAX_RANKS = hrss_pkg::MAX_RANKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hrss_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hrss_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hrss_pkg::STEP_W-1:0]       step_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic                              phase,
  output logic [hrss_pkg::SLICE_W-1:0]      to_rank,
  output logic [hrss_pkg::SLICE_W-1:0]      from_rank,
  output logic [hrss_pkg::SLICE_W-1:0]      slice_count,
  output logic [hrss_pkg::SLICE_W-1:0]      tx_slice,
  output logic [hrss_pkg::SLICE_W-1:0]      rx_slice,
  output logic                              last
);

  localparam int RW = hrss_pkg::RANK_W;
  localparam int SW = hrss_pkg::SLICE_W;
  localparam int UW = hrss_pkg::UNIT_W;
  localparam int HW = hrss_pkg::SHIFT_W;

  hrss_pkg::state_t  state, state_next;
  hrss_pkg::status_t stat;

  logic [RW-1:0] rank_count;
  logic [SW-1:0] my_rank;

  logic [RW-1:0] r;
  logic [RW-1:0] me;
  logic [HW-1:0] s_cnt;
  logic [hrss_pkg::STEP_W-1:0] rem;
  logic [HW-1:0] shift;
  logic          ph;
  logic [RW-1:0] to_q, from_q, tx, rx, dslice;
  logic [SW-1:0] cnt, k;

  logic [UW-1:0] d;
  logic [UW-1:0] a0, b0, m0, y0, y1;
  logic [UW-1:0] cnt_sum;
  logic [UW-1:0] cnt_raw;
  logic [RW-1:0] r_sat;
  logic          slot_free;
  logic          fin;

  assign in_ready  = (state == hrss_pkg::S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign d         = UW'(1) << shift;
  assign cnt_sum   = UW'(r) - UW'(1) + d;
  assign cnt_raw   = cnt_sum >> ({1'b0, shift} + 4'd1);
  assign fin       = (stat != hrss_pkg::STAT_OK) || ((k + SW'(1)) == cnt);
  assign r_sat     = (int'(rank_count) > MAX_RANKS) ? RW'(MAX_RANKS) : rank_count;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count <= RW'(2);
      my_rank    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hrss_pkg::REG_RANK_COUNT: rank_count <= cfg_data[RW-1:0];
        hrss_pkg::REG_MY_RANK:    my_rank    <= cfg_data[SW-1:0];
        default:                  ;
      endcase
    end
  end

  // shared unit operand select
  always_comb begin
    a0 = '0;
    b0 = '0;
    m0 = UW'(r);
    unique case (state)
      hrss_pkg::S_MOD: begin
        a0 = UW'(rem);
        b0 = UW'(s_cnt);
        m0 = UW'(s_cnt);
      end
      hrss_pkg::S_LO: begin
        a0 = UW'(me);
        b0 = d;
      end
      hrss_pkg::S_HI: begin
        a0 = UW'(me) + d;
        b0 = UW'(r);
      end
      hrss_pkg::S_DSL: begin
        a0 = d << 1;
        b0 = UW'(r);
      end
      hrss_pkg::S_EMIT: begin
        a0 = UW'(tx);
        b0 = UW'(dslice);
      end
      default: ;
    endcase
  end

  hrss_sub_unit #(.W(UW)) u_sub (
    .a(a0),
    .b(b0),
    .m(m0),
    .y(y0)
  );

  hrss_sub_unit #(.W(UW)) u_sub_rx (
    .a(UW'(rx)),
    .b(UW'(dslice)),
    .m(UW'(r)),
    .y(y1)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      hrss_pkg::S_IDLE:  if (in_valid) state_next = hrss_pkg::S_CHECK;
      hrss_pkg::S_CHECK: begin
        if (r < RW'(2) || me >= r) begin
          state_next = hrss_pkg::S_EMIT;
        end else if (rem < hrss_pkg::STEP_W'(s_cnt)) begin
          state_next = hrss_pkg::S_LO;
        end else begin
          state_next = hrss_pkg::S_MOD;
        end
      end
      hrss_pkg::S_MOD:   if (rem < hrss_pkg::STEP_W'(s_cnt)) state_next = hrss_pkg::S_LO;
      hrss_pkg::S_LO:    state_next = hrss_pkg::S_HI;
      hrss_pkg::S_HI:    state_next = hrss_pkg::S_DSL;
      hrss_pkg::S_DSL:   state_next = hrss_pkg::S_EMIT;
      hrss_pkg::S_EMIT:  if (slot_free && fin) state_next = hrss_pkg::S_IDLE;
      default:           state_next = hrss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      hrss_pkg::S_IDLE: begin
        if (in_valid) begin
          rem   <= step_index;
          r     <= r_sat;
          me    <= RW'(my_rank);
          s_cnt <= hrss_pkg::bit_len(r_sat - RW'(1));
        end
      end
      hrss_pkg::S_CHECK: begin
        stat   <= hrss_pkg::STAT_OK;
        ph     <= 1'b1;
        to_q   <= '0;
        from_q <= '0;
        tx     <= '0;
        rx     <= '0;
        cnt    <= '0;
        k      <= '0;
        if (r < RW'(2)) begin
          stat <= hrss_pkg::STAT_FEW;
          ph   <= 1'b0;
        end else if (me >= r) begin
          stat <= hrss_pkg::STAT_BAD_RANK;
          ph   <= 1'b0;
        end else if (rem < hrss_pkg::STEP_W'(s_cnt)) begin
          ph    <= 1'b0;
          shift <= rem[HW-1:0];
        end
      end
      hrss_pkg::S_MOD: begin
        if (rem < hrss_pkg::STEP_W'(s_cnt)) begin
          shift <= s_cnt - HW'(1) - rem[HW-1:0];
        end else begin
          rem <= y0[hrss_pkg::STEP_W-1:0];
        end
      end
      hrss_pkg::S_LO: begin
        cnt <= (cnt_raw > UW'(hrss_pkg::CNT_CAP)) ? SW'(hrss_pkg::CNT_CAP) : cnt_raw[SW-1:0];
        if (!ph) begin
          to_q <= y0[RW-1:0];
          tx   <= y0[RW-1:0];
          rx   <= me;
        end else begin
          from_q <= y0[RW-1:0];
          rx     <= y0[RW-1:0];
          tx     <= me;
        end
      end
      hrss_pkg::S_HI: begin
        if (!ph) begin
          from_q <= y0[RW-1:0];
        end else begin
          to_q <= y0[RW-1:0];
        end
      end
      hrss_pkg::S_DSL: begin
        dslice <= y0[RW-1:0];
      end
      hrss_pkg::S_EMIT: begin
        if (slot_free) begin
          tx <= y0[RW-1:0];
          rx <= y1[RW-1:0];
          k  <= k + SW'(1);
        end
      end
      default: ;
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hrss_pkg::S_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hrss_pkg::S_EMIT && slot_free) begin
      status      <= stat;
      phase       <= ph;
      to_rank     <= to_q[SW-1:0];
      from_rank   <= from_q[SW-1:0];
      slice_count <= cnt;
      tx_slice    <= tx[SW-1:0];
      rx_slice    <= rx[SW-1:0];
      last        <= fin;
    end
  end

endmodule

@@ hw/rtl/hrss_sub_unit.sv @@
// ----------------------------------------------------------------------------
// hrss_sub_unit: wrapping subtractor
// Returns a - b, adding the modulus back when the difference goes negative.
// ----------------------------------------------------------------------------
module hrss_sub_unit #(
  parameter int W = hrss_pkg::UNIT_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic [W-1:0] y
);

  logic [W:0]   diff;
  logic         borrow;

  assign diff   = {1'b0, a} - {1'b0, b};
  assign borrow = diff[W];
  assign y      = borrow ? (diff[W-1:0] + m) : diff[W-1:0];

endmodule

@@ verif/tb_halving_ring_step_schedule.sv @@
// ----------------------------------------------------------------------------
// tb_halving_ring_step_schedule: step schedule block testbench
// Sends step numbers under a series of group settings and checks every slice
// beat against a schedule computed in the bench: peers, slice count, slice
// indices and the last flag. Error steps and saturated group sizes are
// covered too. Random input gaps and output back-pressure are set per test, off in the reset-state test.
// ----------------------------------------------------------------------------
module tb_halving_ring_step_schedule;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_STEPS = 480;
  localparam int MAX_GAP      = 18;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    hrss_pkg::status_t            stat;
    logic                         ph;
    logic [hrss_pkg::SLICE_W-1:0] to_r;
    logic [hrss_pkg::SLICE_W-1:0] from_r;
    logic [hrss_pkg::SLICE_W-1:0] cnt;
    logic [hrss_pkg::SLICE_W-1:0] tx;
    logic [hrss_pkg::SLICE_W-1:0] rx;
    logic                         lst;
  } slice_beat_t;

  logic                            clk        = 1'b0;
  logic                            rst        = 1'b1;
  logic                            cfg_we     = 1'b0;
  logic [hrss_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [hrss_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_ready;
  logic [hrss_pkg::STEP_W-1:0]     step_index = '0;
  logic                            out_valid;
  logic                            out_ready  = 1'b0;
  logic [1:0]                      status;
  logic                            phase;
  logic [hrss_pkg::SLICE_W-1:0]    to_rank;
  logic [hrss_pkg::SLICE_W-1:0]    from_rank;
  logic [hrss_pkg::SLICE_W-1:0]    slice_count;
  logic [hrss_pkg::SLICE_W-1:0]    tx_slice;
  logic [hrss_pkg::SLICE_W-1:0]    rx_slice;
  logic                            last;

  slice_beat_t                     slice_beats_due[$];
  logic [hrss_pkg::CFG_DATA_W-1:0] group_size = 7'd2;
  logic [hrss_pkg::SLICE_W-1:0]    own_rank   = '0;
  bit                              gaps_on    = 1'b0;
  bit                              stalls_on  = 1'b0;
  int                              errors      = 0;
  int                              cycle_count = 0;
  int                              stall_left  = 0;

  halving_ring_step_schedule dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .step_index  (step_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .phase       (phase),
    .to_rank     (to_rank),
    .from_rank   (from_rank),
    .slice_count (slice_count),
    .tx_slice    (tx_slice),
    .rx_slice    (rx_slice),
    .last        (last)
  );

  always #5ns clk = ~clk;

  function automatic int unsigned ring_stages(input int unsigned ranks);
    int unsigned v;
    int unsigned n;
    v = ranks - 1;
    n = 0;
    while (v != 0) begin
      v = v >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic void add_due_beat(input slice_beat_t b);
    slice_beats_due = {slice_beats_due, b};
  endfunction

  function automatic void schedule_step(input logic [hrss_pkg::STEP_W-1:0] s);
    int unsigned r, me, stages, d, stride, cnt, tx, rx, to, from, k;
    slice_beat_t b;
    r  = (group_size > hrss_pkg::MAX_RANKS_DEF) ? hrss_pkg::MAX_RANKS_DEF : group_size;
    me = own_rank;
    b = '0;
    b.lst = 1'b1;
    if (r < 2) begin
      b.stat = hrss_pkg::STAT_FEW;
      add_due_beat(b);
    end else if (me >= r) begin
      b.stat = hrss_pkg::STAT_BAD_RANK;
      add_due_beat(b);
    end else begin
      stages = ring_stages(r);
      if (s < stages) begin
        b.ph = 1'b0;
        d    = 1 << s;
        to   = (me + r - d) % r;
        from = (me + d) % r;
        tx   = to;
        rx   = me;
      end else begin
        b.ph = 1'b1;
        d    = 1 << (stages - 1 - (s % stages));
        to   = (me + d) % r;
        from = (me + r - d) % r;
        tx   = me;
        rx   = from;
      end
      stride = (2 * d) % r;
      cnt    = (r - 1 + d) / (2 * d);
      if (cnt > hrss_pkg::CNT_CAP) begin
        cnt = hrss_pkg::CNT_CAP;
      end
      b.stat   = hrss_pkg::STAT_OK;
      b.to_r   = hrss_pkg::SLICE_W'(to);
      b.from_r = hrss_pkg::SLICE_W'(from);
      b.cnt    = hrss_pkg::SLICE_W'(cnt);
      for (k = 0; k < cnt; k++) begin
        b.tx  = hrss_pkg::SLICE_W'(tx);
        b.rx  = hrss_pkg::SLICE_W'(rx);
        b.lst = (k + 1 == cnt);
        add_due_beat(b);
        tx = (tx + r - stride) % r;
        rx = (rx + r - stride) % r;
      end
    end
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Checker and output back-pressure
  always @(posedge clk) begin
    slice_beat_t want;
    int w;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (slice_beats_due.size() == 0) begin
        $error("beat with nothing due: status %0d to_rank %0d tx_slice %0d",
               status, to_rank, tx_slice);
        errors++;
      end else begin
        want = slice_beats_due.pop_front();
        check_field("status", want.stat, status);
        check_field("phase", want.ph, phase);
        check_field("to_rank", want.to_r, to_rank);
        check_field("from_rank", want.from_r, from_rank);
        check_field("slice_count", want.cnt, slice_count);
        check_field("tx_slice", want.tx, tx_slice);
        check_field("rx_slice", want.rx, rx_slice);
        check_field("last", want.lst, last);
      end
      w = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      stall_left <= w;
      out_ready  <= (w == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_halving_ring_step_schedule: done, errors");
      $finish;
    end
  end

  // Hold valid across back-to-back beats; drop it only before a gap
  task automatic send_step(input logic [hrss_pkg::STEP_W-1:0] s);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    step_index <= s;
    do @(posedge clk); while (!in_ready);
    schedule_step(s);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (slice_beats_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_group(input logic [hrss_pkg::CFG_DATA_W-1:0] ranks,
                           input logic [hrss_pkg::CFG_DATA_W-1:0] me);
    cfg_we   <= 1'b1;
    cfg_addr <= hrss_pkg::REG_RANK_COUNT;
    cfg_data <= ranks;
    @(posedge clk);
    cfg_addr <= hrss_pkg::REG_MY_RANK;
    cfg_data <= me;
    @(posedge clk);
    cfg_we <= 1'b0;
    group_size = ranks;
    own_rank   = me[hrss_pkg::SLICE_W-1:0];
  endtask

  task automatic test_reset_state();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_step(4'd0);
    send_step(4'd1);
    send_step(4'd15);
    wait_drained();
  endtask

  task automatic test_error_cases();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    set_group(7'd0, 7'd0);
    send_step(4'd3);
    wait_drained();
    set_group(7'd1, 7'd0);
    send_step(4'd0);
    wait_drained();
    set_group(7'd5, 7'd5);
    send_step(4'd2);
    wait_drained();
    set_group(7'd40, 7'h7F);
    send_step(4'd9);
    wait_drained();
  endtask

  task automatic test_extremes();
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    set_group(7'd64, 7'd0);
    send_step(4'd0);
    send_step(4'd5);
    send_step(4'd6);
    send_step(4'd11);
    send_step(4'd12);
    wait_drained();
    set_group(7'd127, 7'h3F);
    send_step(4'd0);
    send_step(4'd15);
    wait_drained();
    set_group(7'd3, 7'd2);
    send_step(4'd0);
    send_step(4'd1);
    send_step(4'd2);
    send_step(4'd3);
    wait_drained();
  endtask

  task automatic test_random_schedules();
    int sent, n, k;
    int unsigned r, stages;
    logic [hrss_pkg::CFG_DATA_W-1:0] ranks, me;
    sent = 0;
    while (sent < RANDOM_STEPS) begin
      case ($urandom_range(0, 9))
        0:       ranks = hrss_pkg::CFG_DATA_W'($urandom_range(0, 1));
        1:       ranks = hrss_pkg::CFG_DATA_W'($urandom_range(65, 127));
        2:       ranks = 7'd64;
        3:       ranks = hrss_pkg::CFG_DATA_W'($urandom_range(2, 4));
        default: ranks = hrss_pkg::CFG_DATA_W'($urandom_range(2, 64));
      endcase
      r = (ranks > hrss_pkg::MAX_RANKS_DEF) ? hrss_pkg::MAX_RANKS_DEF : ranks;
      if (r >= 2 && $urandom_range(0, 4) != 0) begin
        me = {1'($urandom_range(0, 1)), hrss_pkg::SLICE_W'($urandom_range(0, r - 1))};
      end else begin
        me = hrss_pkg::CFG_DATA_W'($urandom_range(0, 127));
      end
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      set_group(ranks, me);
      if (r >= 2 && $urandom_range(0, 2) != 0) begin
        stages = ring_stages(r);
        for (k = 0; k < 2 * stages; k++) begin
          send_step(hrss_pkg::STEP_W'(k));
        end
        sent += 2 * stages;
      end else begin
        n = $urandom_range(4, 16);
        for (k = 0; k < n; k++) begin
          send_step(hrss_pkg::STEP_W'($urandom_range(0, 15)));
        end
        sent += n;
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_error_cases();
    test_extremes();
    test_random_schedules();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_halving_ring_step_schedule: done, clean");
    end else begin
      $display("tb_halving_ring_step_schedule: done, errors");
    end
    $finish;
  end

endmodule
